// File: rtl/core/nsa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nsa_pkg: shared types and constants for the NFA string acceptor
// Opcodes, the engine command struct and default sizes.
// ----------------------------------------------------------------------------
package nsa_pkg;

   localparam int NUM_STATES_DEF  = 32;
   localparam int NUM_SYMBOLS_DEF = 256;

   // byte whose rows hold the folded epsilon closure
   localparam logic [7:0] EPS_SYMBOL = 8'd38;

   typedef enum logic [1:0] {
      OP_WRITE  = 2'd0,
      OP_START  = 2'd1,
      OP_BYTE   = 2'd2,
      OP_FINISH = 2'd3
   } opcode_type;

   // command handed from the front end to the scan engine
   typedef struct packed {
      logic       valid;
      opcode_type op;
   } nsa_cmd_type;

endpackage
`default_nettype wire

// File: rtl/core/nfa_string_acceptor.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nfa_string_acceptor: bit-vector NFA simulation over a byte stream
// Holds a transition table in RAM and a reached-state vector; reports
// acceptance at the end of each string.
// ----------------------------------------------------------------------------
// After reset the block sweeps the transition table to zero, one entry per
// cycle over all NUM_STATES (capped at 32) times 2**ceil(log2(NUM_SYMBOLS))
// entries, 8192 at the default sizes, during which req_stall stays high (CSR
// writes still work). A row write and a finish are handled while the engine
// stays idle. A start reads the start state's '&' row, then merges it with
// the start state into the reached vector. A byte walks every state once,
// since the table RAM has one read port, reading that state's row for the
// byte and ORing it into an accumulator when the state is reached, then
// merges the accumulator into the reached vector. A finish is taken only
// when the result register is free or being drained; the result register
// lets the next item go in while a result waits on rsp_stall.
// Registers: start_state at byte address 0, accept_mask at byte address 4.
// ----------------------------------------------------------------------------
module nfa_string_acceptor #(
   parameter int NUM_STATES  = nsa_pkg::NUM_STATES_DEF,
   parameter int NUM_SYMBOLS = nsa_pkg::NUM_SYMBOLS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // item input
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_opcode,
   input  wire logic [4:0]  req_row_state,
   input  wire logic [7:0]  req_symbol,
   input  wire logic [31:0] req_next_mask,
   // result output
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_accepted,
   // register port
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);
   import nsa_pkg::*;

   localparam int MASK_BITS = (NUM_STATES < 32) ? NUM_STATES : 32;

   // register file
   logic [4:0]  start_state_ff, start_state_in;
   logic [31:0] accept_mask_ff, accept_mask_in;
   logic        csr_wr;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_accepted_ff, rsp_accepted_in;

   // engine handshake
   nsa_cmd_type          cmd;
   logic                 eng_idle;
   logic [MASK_BITS-1:0] reached;
   logic                 req_accept;
   logic                 finish_accept;
   logic                 rsp_free;
   opcode_type           op;

   assign op = opcode_type'(req_opcode);

   // ------------------------------------------------------------------
   // CSR: word address picks the register, byte offset ignored
   // ------------------------------------------------------------------
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   always_comb begin
      start_state_in = start_state_ff;
      accept_mask_in = accept_mask_ff;
      if (csr_wr) begin
         if (!paddr[2]) begin
            start_state_in = pwdata[4:0];
         end else begin
            accept_mask_in = pwdata;
         end
      end
   end

   assign prdata = paddr[2] ? accept_mask_ff : {27'd0, start_state_ff};

   // ------------------------------------------------------------------
   // Front end: an item goes in only while the engine is idle; a finish
   // additionally needs room in the result register.
   // ------------------------------------------------------------------
   assign rsp_free      = !rsp_valid_ff || !rsp_stall;
   assign req_stall     = !eng_idle || ((op == OP_FINISH) && !rsp_free);
   assign req_accept    = req_valid && !req_stall;
   assign finish_accept = req_accept && (op == OP_FINISH);

   assign cmd.valid = req_accept;
   assign cmd.op    = op;

   // finish leaves reached as is; any accepting reached state hits
   always_comb begin
      rsp_valid_in    = rsp_valid_ff;
      rsp_accepted_in = rsp_accepted_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (finish_accept) begin
         rsp_valid_in    = 1'b1;
         rsp_accepted_in = |(reached & accept_mask_ff[MASK_BITS-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_state_ff <= '0;
         accept_mask_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         start_state_ff <= start_state_in;
         accept_mask_ff <= accept_mask_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      rsp_accepted_ff <= rsp_accepted_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_accepted = rsp_accepted_ff;

   // ------------------------------------------------------------------
   // Table and scan engine
   // ------------------------------------------------------------------
   nsa_engine #(
      .NUM_STATES  (NUM_STATES),
      .NUM_SYMBOLS (NUM_SYMBOLS)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .row_state   (req_row_state),
      .symbol      (req_symbol),
      .next_mask   (req_next_mask),
      .start_state (start_state_ff),
      .idle        (eng_idle),
      .reached     (reached)
   );

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   // nothing is taken while the engine is clearing, starting, scanning or draining
   a_busy_blocks: assert property (@(posedge clock) disable iff (reset)
      !eng_idle |-> req_stall)
      else $error("item input open while engine busy");

   // a byte item must start a scan
   a_byte_scans: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (op == OP_BYTE)) |=> !eng_idle)
      else $error("byte item did not start a scan");

   // a finish always produces a result next cycle
   a_finish_result: assert property (@(posedge clock) disable iff (reset)
      finish_accept |=> rsp_valid)
      else $error("finish item produced no result");

   // only a finish creates a result
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(finish_accept))
      else $error("result appeared without a finish item");

endmodule
`default_nettype wire

// File: rtl/core/nsa_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nsa_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module nsa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8192
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// File: rtl/core/nsa_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nsa_engine: transition table and reached-set scan engine
// Clears the table after reset, loads rows, and folds one row per state
// into the reached vector through a shared OR accumulator.
// ----------------------------------------------------------------------------
module nsa_engine #(
   parameter int NUM_STATES  = 32,
   parameter int NUM_SYMBOLS = 256
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire nsa_pkg::nsa_cmd_type cmd,
   input  wire logic [4:0]           row_state,
   input  wire logic [7:0]           symbol,
   input  wire logic [31:0]          next_mask,
   input  wire logic [4:0]           start_state,
   output logic                      idle,
   output logic [((NUM_STATES < 32) ? NUM_STATES : 32)-1:0] reached
);
   import nsa_pkg::*;

   localparam int MASK_BITS = (NUM_STATES < 32) ? NUM_STATES : 32;
   localparam int ST_W      = $clog2(MASK_BITS);
   localparam int SYM_W     = $clog2(NUM_SYMBOLS);
   localparam int DEPTH     = MASK_BITS * (2 ** SYM_W);
   localparam int AW        = $clog2(DEPTH);
   localparam bit EPS_OK    = (int'(EPS_SYMBOL) < NUM_SYMBOLS);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_START,
      ST_SCAN,
      ST_DRAIN
   } state_type;

   state_type              state_ff, state_in;
   logic [AW-1:0]          clr_ff, clr_in;
   logic [ST_W-1:0]        idx_ff, idx_in;
   logic [MASK_BITS-1:0]   scan_ff, scan_in;
   logic [MASK_BITS-1:0]   acc_ff, acc_in;
   logic [MASK_BITS-1:0]   reached_ff, reached_in;
   logic                   bit_ff, bit_in;
   logic [SYM_W-1:0]       sym_ff, sym_in;
   logic                   sym_ok_ff, sym_ok_in;

   logic                   wr_en;
   logic [AW-1:0]          wr_addr;
   logic [MASK_BITS-1:0]   wr_data;
   logic                   rd_en;
   logic [AW-1:0]          rd_addr;
   logic [MASK_BITS-1:0]   rd_data;
   logic [MASK_BITS-1:0]   row_term;
   logic                   row_ok;
   logic                   sym_ok;
   logic                   start_ok;

   assign row_ok   = ({1'b0, row_state} < 6'(MASK_BITS));
   assign sym_ok   = ({1'b0, symbol} < 9'(NUM_SYMBOLS));
   assign start_ok = ({1'b0, start_state} < 6'(MASK_BITS));

   // shared accumulator input: last row read, gated by its reached bit
   assign row_term = bit_ff ? rd_data : '0;

   always_comb begin
      state_in   = state_ff;
      clr_in     = clr_ff;
      idx_in     = idx_ff;
      scan_in    = scan_ff;
      acc_in     = acc_ff;
      reached_in = reached_ff;
      bit_in     = bit_ff;
      sym_in     = sym_ff;
      sym_ok_in  = sym_ok_ff;
      wr_en      = 1'b0;
      wr_addr    = clr_ff;
      wr_data    = '0;
      rd_en      = 1'b0;
      rd_addr    = {idx_ff, sym_ff};

      case (state_ff)
         ST_CLEAR: begin
            wr_en  = 1'b1;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == AW'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (cmd.valid) begin
               case (cmd.op)
                  OP_WRITE: begin
                     wr_en   = row_ok && sym_ok;
                     wr_addr = {row_state[ST_W-1:0], symbol[SYM_W-1:0]};
                     wr_data = next_mask[MASK_BITS-1:0];
                  end
                  OP_START: begin
                     state_in = ST_START;
                  end
                  OP_BYTE: begin
                     state_in  = ST_SCAN;
                     idx_in    = '0;
                     scan_in   = reached_ff;
                     acc_in    = '0;
                     bit_in    = 1'b0;
                     sym_in    = symbol[SYM_W-1:0];
                     sym_ok_in = sym_ok;
                  end
                  default: ;
               endcase
            end
         end
         ST_START: begin
            rd_en    = 1'b1;
            rd_addr  = {start_state[ST_W-1:0], EPS_SYMBOL[SYM_W-1:0]};
            bit_in   = start_ok && EPS_OK;
            acc_in   = start_ok ? (MASK_BITS'(1) << start_state[ST_W-1:0]) : '0;
            state_in = ST_DRAIN;
         end
         ST_SCAN: begin
            rd_en   = 1'b1;
            acc_in  = acc_ff | row_term;
            bit_in  = scan_ff[0] && sym_ok_ff;
            scan_in = scan_ff >> 1;
            idx_in  = idx_ff + 1'b1;
            if (idx_ff == ST_W'(MASK_BITS - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            reached_in = acc_ff | row_term;
            bit_in     = 1'b0;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         clr_ff     <= '0;
         reached_ff <= '0;
         bit_ff     <= 1'b0;
      end else begin
         state_ff   <= state_in;
         clr_ff     <= clr_in;
         reached_ff <= reached_in;
         bit_ff     <= bit_in;
      end
      idx_ff    <= idx_in;
      scan_ff   <= scan_in;
      acc_ff    <= acc_in;
      sym_ff    <= sym_in;
      sym_ok_ff <= sym_ok_in;
   end

   nsa_ram #(
      .WIDTH (MASK_BITS),
      .DEPTH (DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign idle    = (state_ff == ST_IDLE);
   assign reached = reached_ff;

endmodule
`default_nettype wire
